// ----- rtl/palette_merge_remap_blit_assert.svh -----
// ----------------------------------------------------------------------------
// palette merge remap blit assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PALETTE_MERGE_REMAP_BLIT_ASSERT_SVH
`define PALETTE_MERGE_REMAP_BLIT_ASSERT_SVH

`ifndef SYNTH
`define PMRB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pmrb assertion failed");
`define PMRB_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("pmrb assertion failed");
`else
`define PMRB_ASSERT(name, clk, rst, prop)
`define PMRB_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- rtl/pmrb_pkg.sv -----
// ----------------------------------------------------------------------------
// pmrb_pkg
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pmrb_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = 8;
   localparam int CNT_W      = 9;
   localparam int RGB_W      = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_CLEAR  = 2'd0;
   localparam mode_type MODE_APPEND = 2'd1;
   localparam mode_type MODE_MERGE  = 2'd2;
   localparam mode_type MODE_REMAP  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_TRANSP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_TRANSP = 1'd1;

   localparam logic [CSR_DATA_W-1:0] TRANSP_NONE = 9'd256;

   typedef struct packed {
      logic load;
      logic search_step;
      logic commit;
   } pmrb_cmd_type;

   typedef struct packed {
      logic merge_skip;
      logic hit;
      logic miss;
   } pmrb_status_type;

endpackage

`default_nettype wire

// ----- rtl/palette_merge_remap_blit.sv -----
// ----------------------------------------------------------------------------
// palette_merge_remap_blit
// Destination palette builder and source index remapper.
// ----------------------------------------------------------------------------
// One beat is handled at a time and each gives one result beat. Clear, append
// and remap go from accept straight to S_FIN, which loads the result register
// once it is free. A merge first scans the palette in S_SEARCH through the
// single read port of the palette memory, one entry per cycle, over at most
// entry_count entries; it finishes early on the first match or when the source
// transparent index or a full palette skips the scan. The result register lets
// a new beat be accepted while the previous result still waits to be taken.
// The remap table reads as zero after reset until an entry is written.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_merge_remap_blit import pmrb_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mode_type              req_mode,
   input  logic [IDX_W-1:0]      req_src_index,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   input  logic [IDX_W-1:0]      req_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_W-1:0]      rsp_out_index,
   output logic                  rsp_write_enable,
   output logic                  rsp_added_new,
   output logic                  rsp_overflow,
   output logic [CNT_W-1:0]      rsp_entry_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   pmrb_cmd_type    cmd;
   pmrb_status_type status;

   pmrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pmrb_dp #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_src_index    (req_src_index),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_pixel        (req_pixel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_out_index    (rsp_out_index),
      .rsp_write_enable (rsp_write_enable),
      .rsp_added_new    (rsp_added_new),
      .rsp_overflow     (rsp_overflow),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

`default_nettype wire

// ----- rtl/pmrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// pmrb_ctrl
// Sequencer: accepts a beat, runs the palette scan for merges, and loads
// the result register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "palette_merge_remap_blit_assert.svh"

module pmrb_ctrl import pmrb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  mode_type        req_mode,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  pmrb_status_type status,
   output pmrb_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_FIN    = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd.load         = 1'b0;
      cmd.search_step  = 1'b0;
      cmd.commit       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = (req_mode == MODE_MERGE) ? S_SEARCH : S_FIN;
            end
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.merge_skip || status.hit || status.miss) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PMRB_ASSERT(a_direct_fin, clock, reset, (accept && req_mode != MODE_MERGE) |=> (state_ff == S_FIN))
   `PMRB_ASSERT(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))

endmodule

`default_nettype wire

// ----- rtl/pmrb_dp.sv -----
// ----------------------------------------------------------------------------
// pmrb_dp
// Datapath: palette memory with scan compare, remap table, count, overflow,
// transparency registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "palette_merge_remap_blit_assert.svh"

module pmrb_dp import pmrb_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pmrb_cmd_type          cmd,
   output pmrb_status_type       status,
   input  mode_type              req_mode,
   input  logic [IDX_W-1:0]      req_src_index,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   input  logic [IDX_W-1:0]      req_pixel,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [IDX_W-1:0]      rsp_out_index,
   output logic                  rsp_write_enable,
   output logic                  rsp_added_new,
   output logic                  rsp_overflow,
   output logic [CNT_W-1:0]      rsp_entry_count
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(PALETTE_DEPTH);

   // configuration
   logic [CSR_DATA_W-1:0] src_transp_ff, dst_transp_ff;

   // item registers
   mode_type          mode_ff;
   logic [IDX_W-1:0]  sidx_ff;
   logic [IDX_W-1:0]  pix_ff;
   logic [RGB_W-1:0]  rgb_ff;

   // palette state
   logic [RGB_W-1:0]  pal_mem [PALETTE_DEPTH];
   logic [RGB_W-1:0]  pal_rd_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              pal_we;
   logic              full;

   // scan
   logic [CNT_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  cmp_idx_ff;
   logic              cmp_vld_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  match_ff;
   logic              rd_en;
   logic              hit;

   // remap table
   logic [IDX_W-1:0]      remap_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] remap_vld_ff;
   logic [IDX_W-1:0]      remap_rd_ff;
   logic                  remap_rv_ff;
   logic                  remap_we;
   logic [IDX_W-1:0]      remap_wdata;

   // result
   logic [IDX_W-1:0]  o_idx;
   logic              o_we;
   logic              o_add;
   logic [IDX_W-1:0]  slot;

   assign csr_ready = 1'b1;
   assign full      = (count_ff >= DEPTH_LIM);
   assign slot      = count_ff[IDX_W-1:0];
   assign rd_en     = cmd.search_step && (rd_ptr_ff < count_ff);
   assign hit       = cmp_vld_ff && (cmp_idx_ff != dst_transp_ff) && (pal_rd_ff == rgb_ff);

   assign status.merge_skip = ({1'b0, sidx_ff} == src_transp_ff) || full;
   assign status.hit        = hit;
   assign status.miss       = !cmp_vld_ff && (rd_ptr_ff >= count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_transp_ff <= TRANSP_NONE;
         dst_transp_ff <= TRANSP_NONE;
      end else if (csr_valid) begin
         if (csr_index == CSR_SRC_TRANSP) begin
            src_transp_ff <= csr_wdata;
         end
         if (csr_index == CSR_DST_TRANSP) begin
            dst_transp_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         sidx_ff <= req_src_index;
         pix_ff  <= req_pixel;
         rgb_ff  <= {req_red, req_green, req_blue};
      end
   end

   // scan pipeline: read one entry per cycle, compare the previous one
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.load) begin
         rd_ptr_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.search_step) begin
         cmp_vld_ff <= rd_en;
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
         end
         if (hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         cmp_idx_ff <= rd_ptr_ff;
      end
      if (cmd.search_step && hit) begin
         match_ff <= cmp_idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[count_ff[AW-1:0]] <= rgb_ff;
      end
      if (rd_en) begin
         pal_rd_ff <= pal_mem[rd_ptr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (remap_we) begin
         remap_mem[sidx_ff] <= remap_wdata;
      end
      if (cmd.load) begin
         remap_rd_ff <= remap_mem[req_pixel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remap_vld_ff <= '0;
         remap_rv_ff  <= 1'b0;
      end else begin
         if (remap_we) begin
            remap_vld_ff[sidx_ff] <= 1'b1;
         end
         if (cmd.load) begin
            remap_rv_ff <= remap_vld_ff[req_pixel];
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      pal_we      = 1'b0;
      remap_we    = 1'b0;
      remap_wdata = '0;
      o_idx       = '0;
      o_we        = 1'b0;
      o_add       = 1'b0;
      if (cmd.commit) begin
         unique case (mode_ff)
            MODE_CLEAR: begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
            MODE_APPEND: begin
               if (!full) begin
                  pal_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  o_idx    = slot;
               end
            end
            MODE_MERGE: begin
               if ({1'b0, sidx_ff} != src_transp_ff) begin
                  remap_we = 1'b1;
                  if (full) begin
                     ovf_in = 1'b1;
                  end else if (found_ff) begin
                     o_idx       = match_ff;
                     remap_wdata = match_ff;
                  end else begin
                     pal_we      = 1'b1;
                     count_in    = count_ff + CNT_W'(1);
                     o_idx       = slot;
                     o_add       = 1'b1;
                     remap_wdata = slot;
                  end
               end
            end
            MODE_REMAP: begin
               if ({1'b0, pix_ff} != src_transp_ff) begin
                  o_we  = 1'b1;
                  o_idx = remap_rv_ff ? remap_rd_ff : '0;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_out_index    <= o_idx;
         rsp_write_enable <= o_we;
         rsp_added_new    <= o_add;
         rsp_overflow     <= ovf_in;
         rsp_entry_count  <= count_in;
      end
   end

   `PMRB_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_LIM)
   `PMRB_ASSERT(a_scan_bound, clock, reset, cmd.search_step |-> (rd_ptr_ff <= count_ff))

endmodule

`default_nettype wire
